>>> sv/lcm3_pkg.sv
// Shared constants, types and codes for the three-operand LCM block.
package lcm3_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int IN_WIDTH      = 16;
    localparam int LCM_BITS      = 48;
    localparam int DW            = 3 * OPERAND_WIDTH;
    localparam int KW            = $clog2(OPERAND_WIDTH);
    localparam int CW            = $clog2(OPERAND_WIDTH);
    localparam int EW            = (DW > LCM_BITS) ? DW : LCM_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIV,
        S_MUL,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_GCD,
        OP_DIV,
        OP_MUL
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_ready;
        logic out_load;
    } t_ctl;

    typedef struct packed {
        logic zero;
        logic gcd_eq;
        logic cnt_last;
        logic pair_last;
    } t_sts;

endpackage

>>> sv/lcm3_alu.sv
// Shared add/subtract unit with carry out.
module lcm3_alu import lcm3_pkg::*; (
    input  logic [DW-1:0] i_a,
    input  logic [DW-1:0] i_b,
    input  logic          i_sub,
    output logic [DW-1:0] o_sum,
    output logic          o_carry
);

    logic [DW:0] w_sum;

    assign w_sum   = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + (DW+1)'(i_sub);
    assign o_sum   = w_sum[DW-1:0];
    assign o_carry = w_sum[DW];

endmodule

>>> sv/lcm3_dp.sv
// Datapath: operand, GCD, quotient and product registers around the shared adder.
module lcm3_dp import lcm3_pkg::*; (
    input  logic                i_clk,
    input  t_ctl                i_ctl,
    input  logic [IN_WIDTH-1:0] i_a,
    input  logic [IN_WIDTH-1:0] i_b,
    input  logic [IN_WIDTH-1:0] i_c,
    output t_sts                o_sts,
    output logic [LCM_BITS-1:0] o_lcm,
    output logic                o_err
);

    localparam int W = OPERAND_WIDTH;

    logic [W-1:0]  w_a, w_b, w_c;
    logic [W:0]    w_trial;
    logic [DW-1:0] w_alu_a, w_alu_b, w_sum;
    logic          w_sub, w_carry;
    logic [EW-1:0] w_ext;

    logic [DW-1:0] r_x, n_x, r_u, n_u, r_v, n_v, r_acc, n_acc, r_mx, n_mx;
    logic [W-1:0]  r_y, n_y, r_c, n_c, r_g, n_g, r_q, n_q, r_rem, n_rem;
    logic [KW-1:0] r_k, n_k;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_pair, n_pair, r_err, n_err;

    assign w_a     = W'(i_a);
    assign w_b     = W'(i_b);
    assign w_c     = W'(i_c);
    assign w_trial = {r_rem, r_y[W-1]};

    always_comb begin
        w_alu_a = '0;
        w_alu_b = '0;
        w_sub   = 1'b0;
        unique case (i_ctl.op)
            OP_GCD: begin
                w_alu_a = r_u;
                w_alu_b = r_v;
                w_sub   = 1'b1;
            end
            OP_DIV: begin
                w_alu_a = DW'(w_trial);
                w_alu_b = DW'(r_g);
                w_sub   = 1'b1;
            end
            OP_MUL: begin
                w_alu_a = r_acc;
                w_alu_b = r_q[0] ? r_mx : '0;
            end
            default: begin
            end
        endcase
    end

    lcm3_alu u_alu (
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .i_sub   (w_sub),
        .o_sum   (w_sum),
        .o_carry (w_carry)
    );

    always_comb begin
        n_x = r_x; n_u = r_u; n_v = r_v; n_acc = r_acc; n_mx = r_mx;
        n_y = r_y; n_c = r_c; n_g = r_g; n_q = r_q; n_rem = r_rem;
        n_k = r_k; n_cnt = r_cnt; n_pair = r_pair; n_err = r_err;
        unique case (i_ctl.op)
            OP_LOAD: begin
                n_x    = DW'(w_a);
                n_u    = DW'(w_a);
                n_v    = DW'(w_b);
                n_y    = w_b;
                n_c    = w_c;
                n_k    = '0;
                n_pair = 1'b0;
                n_err  = o_sts.zero;
                n_acc  = '0;
            end
            OP_GCD: begin
                priority if (o_sts.gcd_eq) begin
                    n_g   = W'(r_u << r_k);
                    n_rem = '0;
                    n_q   = '0;
                    n_cnt = '0;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + KW'(1);
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (w_carry) begin
                    n_u = w_sum >> 1;
                end else begin
                    n_u = r_v;
                    n_v = r_u;
                end
            end
            OP_DIV: begin
                n_rem = w_carry ? w_sum[W-1:0] : w_trial[W-1:0];
                n_y   = r_y << 1;
                n_q   = {r_q[W-2:0], w_carry};
                n_cnt = r_cnt + CW'(1);
                if (o_sts.cnt_last) begin
                    n_acc = '0;
                    n_mx  = r_x;
                    n_cnt = '0;
                end
            end
            OP_MUL: begin
                n_acc = w_sum;
                n_mx  = r_mx << 1;
                n_q   = r_q >> 1;
                n_cnt = r_cnt + CW'(1);
                if (o_sts.cnt_last && !r_pair) begin
                    n_x    = w_sum;
                    n_u    = w_sum;
                    n_v    = DW'(r_c);
                    n_y    = r_c;
                    n_k    = '0;
                    n_pair = 1'b1;
                    n_cnt  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_u    <= n_u;
        r_v    <= n_v;
        r_acc  <= n_acc;
        r_mx   <= n_mx;
        r_y    <= n_y;
        r_c    <= n_c;
        r_g    <= n_g;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_k    <= n_k;
        r_cnt  <= n_cnt;
        r_pair <= n_pair;
        r_err  <= n_err;
    end

    assign o_sts.zero      = (w_a == '0) || (w_b == '0) || (w_c == '0);
    assign o_sts.gcd_eq    = (r_u == r_v);
    assign o_sts.cnt_last  = (r_cnt == CW'(W - 1));
    assign o_sts.pair_last = r_pair;

    assign w_ext = EW'(r_acc);
    assign o_lcm = r_err ? '0 :
                   ((w_ext >> LCM_BITS) != '0) ? '1 : w_ext[LCM_BITS-1:0];
    assign o_err = r_err;

endmodule

>>> sv/lcm3_ctrl.sv
// Sequencer: steps the datapath through GCD, divide and multiply for each pair.
module lcm3_ctrl import lcm3_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    input  logic i_out_free,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_state = i_sts.zero ? S_DONE : S_GCD;
                end
            end
            S_GCD: begin
                if (i_sts.gcd_eq) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.cnt_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (i_sts.cnt_last) begin
                    n_state = i_sts.pair_last ? S_DONE : S_GCD;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl = '{op: OP_NONE, in_ready: 1'b0, out_load: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                o_ctl.in_ready = 1'b1;
                o_ctl.op       = i_s_valid ? OP_LOAD : OP_NONE;
            end
            S_GCD:  o_ctl.op = OP_GCD;
            S_DIV:  o_ctl.op = OP_DIV;
            S_MUL:  o_ctl.op = OP_MUL;
            S_DONE: o_ctl.out_load = i_out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/lcm_of_three.sv
// Top level: least common multiple of three unsigned operands.
//
//  channel | dir | tdata (low bit up)                                | tuser
//  s_*     | in  | operand_a[15:0] operand_b[31:16] operand_c[47:32] | -
//  m_*     | out | lcm_value[47:0]                                   | zero_error
//
// Each beat is reduced pairwise: binary GCD (one shift, subtract-and-shift or swap per
// cycle), then restoring divide and shift-add multiply, all through one adder.
// A beat with a zero operand skips the arithmetic.
// Input is held off while a beat is in work; a full output register holds the sequencer.
// Reset is synchronous, active low, and clears the sequencer and output valid.
module lcm_of_three import lcm3_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [3*IN_WIDTH-1:0] i_s_tdata,  // operand_a, operand_b, operand_c
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [LCM_BITS-1:0]   o_m_tdata,  // lcm_value
    output logic                  o_m_tuser   // zero_error
);

    t_ctl                w_ctl;
    t_sts                w_sts;
    logic                w_out_free;
    logic [LCM_BITS-1:0] w_lcm;
    logic                w_err;

    logic                r_out_valid;
    logic [LCM_BITS-1:0] r_out_data;
    logic                r_out_err;

    assign w_out_free = !r_out_valid || i_m_tready;

    lcm3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (i_s_tvalid),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    lcm3_dp u_dp (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_a   (i_s_tdata[IN_WIDTH-1:0]),
        .i_b   (i_s_tdata[2*IN_WIDTH-1:IN_WIDTH]),
        .i_c   (i_s_tdata[3*IN_WIDTH-1:2*IN_WIDTH]),
        .o_sts (w_sts),
        .o_lcm (w_lcm),
        .o_err (w_err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.out_load) begin
            r_out_data <= w_lcm;
            r_out_err  <= w_err;
        end
    end

    assign o_s_tready = w_ctl.in_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_err;

endmodule
